>>> hdl/ifsc_pkg.sv
// Shared constants and controller/datapath interface types for the image flip-shift copy block.
package ifsc_pkg;

  // Image limits and the size of the element store.
  localparam int unsigned MaxHeight   = 64;
  localparam int unsigned MaxWidth    = 64;
  localparam int unsigned MaxChannels = 4;
  localparam int unsigned StoreDepth  = MaxHeight * MaxWidth * MaxChannels;

  // Field and register widths.
  localparam int unsigned SampleW  = 8;
  localparam int unsigned SizeW    = 7;
  localparam int unsigned ChanCfgW = 3;
  localparam int unsigned ShiftW   = 8;
  localparam int unsigned FlipW    = 3;
  localparam int unsigned CfgIdxW  = 3;

  // Internal widths derived from the limits.
  localparam int unsigned CoordW = $clog2(MaxHeight);
  localparam int unsigned ChanW  = $clog2(MaxChannels);
  localparam int unsigned AddrW  = $clog2(StoreDepth);
  localparam int unsigned PixW   = $clog2(MaxHeight * MaxWidth);
  localparam int unsigned AreaW  = PixW + 1;
  localparam int unsigned TotalW = AddrW + 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegHeight   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWidth    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegChannels = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPlanar   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRowShift = 3'd4;
  localparam logic [CfgIdxW-1:0] RegColShift = 3'd5;
  localparam logic [CfgIdxW-1:0] RegFlip     = 3'd6;

  // Bits of the flip mode register.
  localparam int unsigned FlipVertBit = 0;
  localparam int unsigned FlipHorzBit = 1;
  localparam int unsigned FlipSwapBit = 2;

  // Operation codes carried in tuser.
  localparam logic OpLoad  = 1'b0;
  localparam logic OpFetch = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic eval;
    logic mult;
    logic addr;
    logic rd_en;
    logic push;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_fetch;
    logic out_free;
  } sts_t;

endpackage

>>> hdl/ifsc_ctrl.sv
// Controller state machine that sequences one beat at a time through the datapath.
module ifsc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ifsc_pkg::sts_t  sts_i,
  output ifsc_pkg::cmd_t  cmd_o
);
  import ifsc_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StEval,
    StMult,
    StAddr,
    StRead,
    StPush
  } state_e;

  state_e state_q;

  // A new beat is taken only between items.
  assign in_ready_o = (state_q == StIdle);

  // Commands decode from the current state, with capture also gated by input valid and push by a free output register.
  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = (state_q == StIdle) && in_valid_i;
    cmd_o.eval    = (state_q == StEval);
    cmd_o.mult    = (state_q == StMult);
    cmd_o.addr    = (state_q == StAddr);
    cmd_o.rd_en   = (state_q == StRead);
    cmd_o.push    = (state_q == StPush) && sts_i.out_free;
  end

  // State register and transitions.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) state_q <= StEval;
        end
        StEval: state_q <= StMult;
        StMult: state_q <= StAddr;
        StAddr: begin
          if (sts_i.is_fetch) state_q <= StRead;
          else state_q <= StIdle;
        end
        StRead: state_q <= StPush;
        StPush: begin
          if (sts_i.out_free) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

>>> hdl/ifsc_datapath.sv
// Datapath: configuration registers, counters, address arithmetic, image store and output register.
module ifsc_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ifsc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ifsc_pkg::ShiftW-1:0]       cfg_data_i,
  input  logic [ifsc_pkg::SampleW-1:0]      in_data_i,
  input  logic                              in_user_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ifsc_pkg::SampleW-1:0]      out_data_o,
  output logic                              out_last_o,
  input  ifsc_pkg::cmd_t                    cmd_i,
  output ifsc_pkg::sts_t                    sts_o
);
  import ifsc_pkg::*;

  // Signed width for source coordinates before clamping.
  localparam int unsigned SW = 10;

  // Configuration registers.
  logic [SizeW-1:0]         height_q, width_q;
  logic [ChanCfgW-1:0]      chan_cfg_q;
  logic                     planar_q;
  logic signed [ShiftW-1:0] row_shift_q, col_shift_q;
  logic [FlipW-1:0]         flip_q;

  // Captured beat.
  logic                     op_q;
  logic [SampleW-1:0]       sample_q;

  // Position counters.
  logic [CoordW-1:0]        row_q, col_q;
  logic [ChanW-1:0]         chan_q;
  logic [AddrW-1:0]         load_q;

  // Stage registers.
  logic [CoordW-1:0]        sy_q, sx_q;
  logic [ChanW-1:0]         sc_q;
  logic                     last_q;
  logic [AreaW-1:0]         area_q;
  logic [PixW-1:0]          pix_q;
  logic [AddrW-1:0]         plane_q;
  logic [TotalW-1:0]        total_q;
  logic [AddrW-1:0]         addr_q;
  logic [SampleW-1:0]       rdata_q;

  // Output register.
  logic                     out_valid_q;
  logic [SampleW-1:0]       out_data_q;
  logic                     out_last_q;

  logic [SampleW-1:0]       store_mem [StoreDepth];

  // Combinational helpers.
  logic [SizeW-1:0]         h_eff, w_eff, h_m1, w_m1;
  logic [ChanCfgW-1:0]      ch_eff, ch_m1;
  logic [CoordW-1:0]        y, x, sy, sx;
  logic [ChanW-1:0]         c, sc;
  logic                     x_end, y_end, c_end;
  logic [CoordW-1:0]        row_d, col_d;
  logic [ChanW-1:0]         chan_d;
  logic signed [SW-1:0]     sy_raw, sx_raw, h_s, w_s, y_s, x_s, rs_s, cs_s;
  logic [AddrW-1:0]         pos;
  logic [TotalW-1:0]        pos_inc;
  logic [AddrW-1:0]         load_d;
  logic                     wr_en;

  assign cfg_ready_o = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q    <= SizeW'(MaxHeight);
      width_q     <= SizeW'(MaxWidth);
      chan_cfg_q  <= ChanCfgW'(3);
      planar_q    <= 1'b0;
      row_shift_q <= '0;
      col_shift_q <= '0;
      flip_q      <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegHeight:   height_q    <= cfg_data_i[SizeW-1:0];
        RegWidth:    width_q     <= cfg_data_i[SizeW-1:0];
        RegChannels: chan_cfg_q  <= cfg_data_i[ChanCfgW-1:0];
        RegPlanar:   planar_q    <= cfg_data_i[0];
        RegRowShift: row_shift_q <= signed'(cfg_data_i);
        RegColShift: col_shift_q <= signed'(cfg_data_i);
        RegFlip:     flip_q      <= cfg_data_i[FlipW-1:0];
        default: ;
      endcase
    end
  end

  // Sizes bounded to their legal ranges.
  always_comb begin
    if (height_q == '0) h_eff = SizeW'(1);
    else if (height_q > SizeW'(MaxHeight)) h_eff = SizeW'(MaxHeight);
    else h_eff = height_q;
    if (width_q == '0) w_eff = SizeW'(1);
    else if (width_q > SizeW'(MaxWidth)) w_eff = SizeW'(MaxWidth);
    else w_eff = width_q;
    if (chan_cfg_q == '0) ch_eff = ChanCfgW'(1);
    else if (chan_cfg_q > ChanCfgW'(MaxChannels)) ch_eff = ChanCfgW'(MaxChannels);
    else ch_eff = chan_cfg_q;
    h_m1  = h_eff - SizeW'(1);
    w_m1  = w_eff - SizeW'(1);
    ch_m1 = ch_eff - ChanCfgW'(1);
  end

  // Counters beyond the current size count as zero.
  always_comb begin
    y = (SizeW'(row_q) >= h_eff) ? '0 : row_q;
    x = (SizeW'(col_q) >= w_eff) ? '0 : col_q;
    c = (ChanCfgW'(chan_q) >= ch_eff) ? '0 : chan_q;
    x_end = (SizeW'(x) == w_m1);
    y_end = (SizeW'(y) == h_m1);
    c_end = (ChanCfgW'(c) == ch_m1);
  end

  // Source coordinates after flip and shift, clamped to the image edge.
  always_comb begin
    h_s  = signed'(SW'(h_eff));
    w_s  = signed'(SW'(w_eff));
    y_s  = signed'(SW'(y));
    x_s  = signed'(SW'(x));
    rs_s = SW'(row_shift_q);
    cs_s = SW'(col_shift_q);
    if (flip_q[FlipVertBit]) sy_raw = h_s - y_s - SW'(1) + rs_s;
    else sy_raw = y_s - rs_s;
    if (flip_q[FlipHorzBit]) sx_raw = w_s - x_s - SW'(1) + cs_s;
    else sx_raw = x_s - cs_s;
    if (sy_raw < 0) sy = '0;
    else if (sy_raw >= h_s) sy = h_m1[CoordW-1:0];
    else sy = sy_raw[CoordW-1:0];
    if (sx_raw < 0) sx = '0;
    else if (sx_raw >= w_s) sx = w_m1[CoordW-1:0];
    else sx = sx_raw[CoordW-1:0];
    if (flip_q[FlipSwapBit] && (ch_eff >= ChanCfgW'(3)) && (c < ChanW'(3)))
      sc = ChanW'(2) - c;
    else
      sc = c;
  end

  // Next destination position, in destination memory order.
  always_comb begin
    if (planar_q) begin
      col_d  = x_end ? '0 : x + CoordW'(1);
      row_d  = x_end ? (y_end ? '0 : y + CoordW'(1)) : y;
      chan_d = (x_end && y_end) ? (c_end ? '0 : c + ChanW'(1)) : c;
    end else begin
      chan_d = c_end ? '0 : c + ChanW'(1);
      col_d  = c_end ? (x_end ? '0 : x + CoordW'(1)) : x;
      row_d  = (c_end && x_end) ? (y_end ? '0 : y + CoordW'(1)) : y;
    end
  end

  // Load position with wrap at the image size.
  always_comb begin
    pos     = (TotalW'(load_q) >= total_q) ? '0 : load_q;
    pos_inc = TotalW'(pos) + TotalW'(1);
    load_d  = (pos_inc >= total_q) ? '0 : pos_inc[AddrW-1:0];
    wr_en   = cmd_i.addr && (op_q == OpLoad);
  end

  // Beat capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= in_user_i;
      sample_q <= in_data_i;
    end
  end

  // Counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      chan_q <= '0;
      load_q <= '0;
    end else begin
      if (cmd_i.eval && (op_q == OpFetch)) begin
        row_q  <= row_d;
        col_q  <= col_d;
        chan_q <= chan_d;
      end
      if (wr_en) load_q <= load_d;
    end
  end

  // Evaluate, multiply and address stages.
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      sy_q   <= sy;
      sx_q   <= sx;
      sc_q   <= sc;
      last_q <= y_end && x_end && c_end;
      area_q <= AreaW'(h_eff) * AreaW'(w_eff);
    end
    if (cmd_i.mult) begin
      pix_q   <= PixW'(AreaW'(sy_q) * AreaW'(w_eff) + AreaW'(sx_q));
      plane_q <= AddrW'(sc_q) * AddrW'(area_q);
      total_q <= TotalW'(area_q) * TotalW'(ch_eff);
    end
    if (cmd_i.addr) begin
      if (planar_q) addr_q <= plane_q + AddrW'(pix_q);
      else addr_q <= AddrW'(pix_q) * AddrW'(ch_eff) + AddrW'(sc_q);
    end
  end

  // Single-port image store with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en) store_mem[pos] <= sample_q;
    if (cmd_i.rd_en) rdata_q <= store_mem[addr_q];
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_data_q <= rdata_q;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign out_last_o      = out_last_q;
  assign sts_o.is_fetch  = (op_q == OpFetch);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

>>> hdl/image_flip_shift_copy.sv
// Top level of the image flip-shift copy block: controller, datapath and checks.
//
// Software loads an image, one element per input beat with tuser low, in source
// memory order into a 16384-entry store; beats with tuser high each return the next
// destination element, flipped, shifted and clamped at the image edge, with tlast on
// the final element. The block works on one beat at a time: a load runs the idle,
// evaluate, multiply and address states; a fetch adds read and push and any wait for
// the output register to drain. These steps follow the address chain (bounds and
// clamp, then two registered multiply steps) and the single-port store's registered
// read. The store has no reset and no clearing pass; elements read before they were
// loaded hold arbitrary data. The cfg channel is always ready; the user must write
// configuration only while the block is idle, which the block does not enforce.
module image_flip_shift_copy (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ifsc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ifsc_pkg::ShiftW-1:0]       cfg_data_i,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ifsc_pkg::SampleW-1:0]      s_axis_tdata,  // [7:0] sample
  input  logic                              s_axis_tuser,  // [0] operation
  // Output stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ifsc_pkg::SampleW-1:0]      m_axis_tdata,  // [7:0] pixel_value
  output logic                              m_axis_tlast
);
  import ifsc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  ifsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic, counters and storage.
  ifsc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

`ifndef SYNTH
  // A result is pushed only into a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> sts.out_free)
    else $error("result pushed into a full output register");

  // Only one beat is in flight at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // A store read is always followed by the push phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |=> !s_axis_tready && !cmd.rd_en)
    else $error("store read not followed by push phase");
`endif

endmodule

>>> sim/flip_shift_checker.sv
// Checker for the image flip-shift copy block: predicts each destination element and compares it.
module flip_shift_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write channel, observed only.
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [ifsc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ifsc_pkg::ShiftW-1:0]  cfg_data_i,
  // Input stream, observed only.
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [ifsc_pkg::SampleW-1:0] in_sample_i,
  input  logic                         in_op_i,
  // Output stream, observed only.
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [ifsc_pkg::SampleW-1:0] out_pixel_i,
  input  logic                         out_last_i,
  // Status for the testbench top.
  output int                           pending_o,
  output int                           errors_o,
  output int                           loads_o,
  output int                           compares_o,
  output int                           frames_o
);
  import ifsc_pkg::*;

  localparam int unsigned RgbChannels = 3;
  localparam int unsigned MaxReported = 10;

  typedef struct packed {
    logic [SampleW-1:0] pixel;
    logic               last;
  } dest_elem_t;

  // Shadow of the element store and of the block's counters.
  logic [SampleW-1:0] image_mem [StoreDepth];
  dest_elem_t         dest_elems_q [$];
  dest_elem_t         expected_elem;
  int unsigned        load_pos;
  int unsigned        row_pos;
  int unsigned        col_pos;
  int unsigned        chan_pos;
  int unsigned        frame_len;

  // Shadow of the configuration registers.
  logic [SizeW-1:0]         height_q;
  logic [SizeW-1:0]         width_q;
  logic [ChanCfgW-1:0]      chans_q;
  logic                     planar_q;
  logic signed [ShiftW-1:0] row_shift_q;
  logic signed [ShiftW-1:0] col_shift_q;
  logic [FlipW-1:0]         flip_q;

  // A size of zero acts as one, and a size above the limit acts as the limit.
  function automatic int unsigned eff_size(int unsigned raw, int unsigned limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  function automatic int clamp_edge(int v, int n);
    if (v < 0) return 0;
    if (v >= n) return n - 1;
    return v;
  endfunction

  // Works out the next destination element and steps the destination counters.
  function automatic dest_elem_t next_dest_element();
    int unsigned h;
    int unsigned w;
    int unsigned ch;
    int unsigned sc;
    int unsigned addr;
    int          sy;
    int          sx;
    dest_elem_t  elem;
    h  = eff_size(height_q, MaxHeight);
    w  = eff_size(width_q, MaxWidth);
    ch = eff_size(chans_q, MaxChannels);
    // Counters left beyond a shrunken image restart at zero.
    if (row_pos >= h) row_pos = 0;
    if (col_pos >= w) col_pos = 0;
    if (chan_pos >= ch) chan_pos = 0;

    // Source coordinates after flip and shift, clamped to the image edge.
    if (flip_q[FlipVertBit]) sy = int'(h) - 1 - int'(row_pos) + int'(row_shift_q);
    else sy = int'(row_pos) - int'(row_shift_q);
    if (flip_q[FlipHorzBit]) sx = int'(w) - 1 - int'(col_pos) + int'(col_shift_q);
    else sx = int'(col_pos) - int'(col_shift_q);
    sy = clamp_edge(sy, int'(h));
    sx = clamp_edge(sx, int'(w));

    // The RGB swap only applies to images with at least three channels.
    sc = chan_pos;
    if (flip_q[FlipSwapBit] && ch >= RgbChannels && chan_pos < RgbChannels) begin
      sc = RgbChannels - 1 - chan_pos;
    end

    if (planar_q) addr = sc * h * w + int'(unsigned'(sy)) * w + int'(unsigned'(sx));
    else addr = (int'(unsigned'(sy)) * w + int'(unsigned'(sx))) * ch + sc;

    elem.pixel = image_mem[addr];
    elem.last  = (row_pos == h - 1) && (col_pos == w - 1) && (chan_pos == ch - 1);

    // Planar output runs column, row, channel; interleaved runs channel, column, row.
    if (planar_q) begin
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) begin
          row_pos = 0;
          chan_pos++;
          if (chan_pos >= ch) chan_pos = 0;
        end
      end
    end else begin
      chan_pos++;
      if (chan_pos >= ch) begin
        chan_pos = 0;
        col_pos++;
        if (col_pos >= w) begin
          col_pos = 0;
          row_pos++;
          if (row_pos >= h) row_pos = 0;
        end
      end
    end
    return elem;
  endfunction

  // Output beats are checked before this edge's input beat is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_elems_q.delete();
      load_pos    = 0;
      row_pos     = 0;
      col_pos     = 0;
      chan_pos    = 0;
      height_q    = SizeW'(MaxHeight);
      width_q     = SizeW'(MaxWidth);
      chans_q     = ChanCfgW'(3);
      planar_q    = 1'b0;
      row_shift_q = '0;
      col_shift_q = '0;
      flip_q      = '0;
    end else begin
      // Compare an output beat with the oldest expected element.
      if (out_valid_i && out_ready_i) begin
        if (dest_elems_q.size() == 0) begin
          errors_o++;
          if (errors_o <= MaxReported) begin
            $display("%0t: output beat with nothing expected: pixel %h last %b",
                     $time, out_pixel_i, out_last_i);
          end
        end else begin
          expected_elem = dest_elems_q.pop_front();
          compares_o++;
          if (expected_elem.last) frames_o++;
          if (out_pixel_i !== expected_elem.pixel || out_last_i !== expected_elem.last) begin
            errors_o++;
            if (errors_o <= MaxReported) begin
              $display({"%0t: element %0d mismatch: pixel expected %h got %h, ",
                        "last expected %b got %b"},
                       $time, compares_o, expected_elem.pixel, out_pixel_i,
                       expected_elem.last, out_last_i);
            end
          end
        end
      end

      // Register writes; upper data bits beyond a register's width are dropped.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegHeight:   height_q    = cfg_data_i[SizeW-1:0];
          RegWidth:    width_q     = cfg_data_i[SizeW-1:0];
          RegChannels: chans_q     = cfg_data_i[ChanCfgW-1:0];
          RegPlanar:   planar_q    = cfg_data_i[0];
          RegRowShift: row_shift_q = cfg_data_i;
          RegColShift: col_shift_q = cfg_data_i;
          RegFlip:     flip_q      = cfg_data_i[FlipW-1:0];
          default: ;
        endcase
      end

      // A load beat writes the store; a fetch beat expects one element.
      if (in_valid_i && in_ready_i) begin
        if (in_op_i == OpLoad) begin
          frame_len = eff_size(height_q, MaxHeight) * eff_size(width_q, MaxWidth)
                      * eff_size(chans_q, MaxChannels);
          if (load_pos >= frame_len) load_pos = 0;
          image_mem[load_pos] = in_sample_i;
          load_pos++;
          if (load_pos >= frame_len) load_pos = 0;
          loads_o++;
        end else begin
          dest_elems_q.push_back(next_dest_element());
        end
      end
    end
    pending_o = dest_elems_q.size();
  end

endmodule

>>> sim/image_flip_shift_copy_tb.sv
// Testbench top for the image flip-shift copy block: stimulus, flow control and verdict.
module image_flip_shift_copy_tb;
  import ifsc_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpare       = 3'd7;
  localparam logic [FlipW-1:0]   VertFlip       = FlipW'(1 << FlipVertBit);
  localparam logic [FlipW-1:0]   HorzFlip       = FlipW'(1 << FlipHorzBit);
  localparam logic [FlipW-1:0]   RgbSwap        = FlipW'(1 << FlipSwapBit);
  localparam int unsigned        RandomPhases   = 6;
  localparam int unsigned        PressurePhase  = 3;
  localparam int unsigned        LongHoldCycles = 400;
  localparam int unsigned        SettleCycles   = 12;

  localparam logic [SampleW-1:0] CornerSamples [12] = '{
    8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h7F, 8'hFE, 8'h33, 8'hCC
  };

  typedef struct {
    logic [SizeW-1:0]    height;
    logic [SizeW-1:0]    width;
    logic [ChanCfgW-1:0] chans;
    logic                planar;
    logic [ShiftW-1:0]   row_shift;
    logic [ShiftW-1:0]   col_shift;
    logic [FlipW-1:0]    flip;
  } frame_cfg_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [ShiftW-1:0]  cfg_data;

  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [SampleW-1:0] s_axis_tdata;  // [7:0] sample
  logic               s_axis_tuser;  // [0] operation

  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [SampleW-1:0] m_axis_tdata;  // [7:0] pixel_value
  logic               m_axis_tlast;

  int pending;
  int errors;
  int loads;
  int compares;
  int frames;

  frame_cfg_t  cfg;
  int unsigned settings = 0;
  int unsigned hold_asks = 0;
  int unsigned holds_done = 0;
  int unsigned loaded_extent = 0;
  bit          no_gaps = 1'b0;

  always #2 clk_i = ~clk_i;

  image_flip_shift_copy i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  flip_shift_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_sample_i (s_axis_tdata),
    .in_op_i     (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pixel_i (m_axis_tdata),
    .out_last_i  (m_axis_tlast),
    .pending_o   (pending),
    .errors_o    (errors),
    .loads_o     (loads),
    .compares_o  (compares),
    .frames_o    (frames)
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned eff_dim(int unsigned raw, int unsigned limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  // Number of elements in one image under the current settings.
  function automatic int unsigned frame_total();
    return eff_dim(cfg.height, MaxHeight) * eff_dim(cfg.width, MaxWidth)
           * eff_dim(cfg.chans, MaxChannels);
  endfunction

  // Zero, the limit, or a raw value above the limit.
  function automatic logic [SizeW-1:0] extreme_size();
    int unsigned r;
    r = $urandom_range(0, 2);
    if (r == 0) return '0;
    if (r == 1) return SizeW'(MaxHeight);
    return SizeW'($urandom_range(MaxHeight + 1, (1 << SizeW) - 1));
  endfunction

  function automatic logic [ShiftW-1:0] pick_shift();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return ShiftW'(int'($urandom_range(0, 8)) - 4);
    if (r < 8) return ShiftW'(int'($urandom_range(0, 16)) - 8);
    return ShiftW'($urandom);
  endfunction

  // One input beat, optionally preceded by an idle gap.
  task automatic send_beat(logic op, logic [SampleW-1:0] sample);
    int unsigned gap;
    gap = no_gaps ? 0 : idle_cycles();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= sample;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic cfg_beat(logic [CfgIdxW-1:0] idx, logic [ShiftW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk_i);
    while (!cfg_ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Stop sending, wait until every expected element has come, then let the block settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes every register from cfg, with random bits above each register's width.
  task automatic apply_cfg();
    logic [ShiftW-1:0] junk;
    wait_idle();
    junk = ShiftW'($urandom);
    cfg_beat(RegHeight, {junk[ShiftW-1:SizeW], cfg.height});
    cfg_beat(RegWidth, {junk[ShiftW-1:SizeW], cfg.width});
    cfg_beat(RegChannels, {junk[ShiftW-1:ChanCfgW], cfg.chans});
    cfg_beat(RegPlanar, {junk[ShiftW-1:1], cfg.planar});
    cfg_beat(RegRowShift, cfg.row_shift);
    cfg_beat(RegColShift, cfg.col_shift);
    cfg_beat(RegFlip, {junk[ShiftW-1:FlipW], cfg.flip});
    if ($urandom_range(0, 3) == 0) cfg_beat(RegSpare, ShiftW'($urandom));
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Loads one whole image, which covers every address the next fetches can read.
  task automatic load_frame();
    int unsigned total;
    total = frame_total();
    repeat (total) send_beat(OpLoad, SampleW'($urandom));
    if (total > loaded_extent) loaded_extent = total;
  endtask

  // Back-to-back fetches while the receiver holds off, so the input backs up.
  task automatic stalled_fetches();
    bit saved;
    saved = no_gaps;
    no_gaps = 1'b1;
    hold_asks++;
    repeat (40) send_beat(OpFetch, SampleW'($urandom));
    no_gaps = saved;
  endtask

  task automatic mixed_beats(int unsigned count);
    repeat (count) begin
      send_beat(($urandom_range(0, 3) == 0) ? OpLoad : OpFetch, SampleW'($urandom));
    end
  endtask

  // Stimulus: directed settings first, then random settings.
  initial begin
    int unsigned kind;
    rst_ni        = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OpLoad;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Small interleaved image with the RGB swap, corner sample values, one full frame out.
    cfg = '{height: 7'd2, width: 7'd2, chans: 3'd3, planar: 1'b0,
            row_shift: '0, col_shift: '0, flip: RgbSwap};
    apply_cfg();
    foreach (CornerSamples[i]) send_beat(OpLoad, CornerSamples[i]);
    loaded_extent = frame_total();
    repeat (12) send_beat(OpFetch, SampleW'($urandom));

    // Zero height and channels, oversized width, planar, shifts at the signed extremes.
    cfg = '{height: 7'd0, width: 7'd127, chans: 3'd0, planar: 1'b1,
            row_shift: 8'h80, col_shift: 8'h7F, flip: VertFlip | HorzFlip | RgbSwap};
    apply_cfg();
    load_frame();
    mixed_beats(30);

    // Oversized height and channels, zero width, shifts as large as the image.
    cfg = '{height: 7'd127, width: 7'd0, chans: 3'd7, planar: 1'b0,
            row_shift: 8'h40, col_shift: 8'hC0, flip: VertFlip | HorzFlip};
    apply_cfg();
    load_frame();
    mixed_beats(30);

    // A medium image with four channels, random layout, shifts and flips.
    cfg = '{height: 7'd8, width: 7'd6, chans: 3'd4, planar: 1'($urandom_range(0, 1)),
            row_shift: pick_shift(), col_shift: pick_shift(),
            flip: FlipW'($urandom_range(0, 7))};
    apply_cfg();
    load_frame();
    stalled_fetches();
    mixed_beats(60);

    for (int p = 0; p < RandomPhases; p++) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        cfg.height = SizeW'($urandom_range(1, 6));
        cfg.width  = SizeW'($urandom_range(1, 6));
      end else if (kind == 7) begin
        cfg.height = extreme_size();
        cfg.width  = SizeW'($urandom_range(0, 2));
      end else if (kind == 8) begin
        cfg.height = SizeW'($urandom_range(0, 2));
        cfg.width  = extreme_size();
      end else begin
        cfg.height = SizeW'($urandom_range(1, 12));
        cfg.width  = SizeW'($urandom_range(1, 12));
      end
      cfg.chans     = ChanCfgW'($urandom_range(0, 7));
      cfg.planar    = 1'($urandom_range(0, 1));
      cfg.row_shift = pick_shift();
      cfg.col_shift = pick_shift();
      cfg.flip      = FlipW'($urandom_range(0, 7));
      no_gaps = ($urandom_range(0, 4) == 0);
      apply_cfg();
      // Reloading is skipped only when earlier loads cover every address of the new image.
      if (frame_total() > loaded_extent || $urandom_range(0, 1) == 0) load_frame();
      if (p == PressurePhase) stalled_fetches();
      mixed_beats($urandom_range(15, 35));
    end

    wait_idle();
    $display("Covered %0d register settings with %0d loaded elements.", settings, loads);
    $display("Compared %0d output elements, %0d of them frame ends.", compares, frames);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Receiver: random ready pattern, plus a long hold whenever the stimulus asks for one.
  initial begin
    int unsigned ready_len;
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (holds_done != hold_asks) begin
        m_axis_tready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
        holds_done++;
      end else begin
        m_axis_tready <= 1'b1;
        ready_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
        while (ready_len != 0 && holds_done == hold_asks) begin
          @(posedge clk_i);
          ready_len--;
        end
        stall = idle_cycles();
        if (stall != 0 && holds_done == hold_asks) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #20_000_000;
    $display("Timeout: the run did not finish in the allowed time");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
